// ----- rtl/utfv_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text validator package
// Byte ranges, code point limits and widths shared by the validator.
// ----------------------------------------------------------------------------
package utfv_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned TAIL_W = 2;
  localparam int unsigned MINC_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [TAIL_W-1:0] tails_t;
  typedef logic [MINC_W-1:0] min_class_t;

  // Lead byte ranges.
  localparam byte_t LEAD2_LO = 8'hC2;
  localparam byte_t LEAD2_HI = 8'hDF;
  localparam byte_t LEAD3_LO = 8'hE0;
  localparam byte_t LEAD3_HI = 8'hEF;
  localparam byte_t LEAD4_LO = 8'hF0;
  localparam byte_t LEAD4_HI = 8'hF4;

  // Single-byte characters that are rejected.
  localparam byte_t CTRL_LIMIT = 8'h20;
  localparam byte_t DEL_BYTE   = 8'h7F;
  localparam byte_t ASCII_TOP  = 8'h7F;

  localparam byte_t CONT_MASK = 8'hC0;
  localparam byte_t CONT_MARK = 8'h80;

  // Sequence class codes; min_code_point gives the minimum code point of each.
  localparam min_class_t CLASS_TWO   = 2'd0;
  localparam min_class_t CLASS_THREE = 2'd1;
  localparam min_class_t CLASS_FOUR  = 2'd2;

  localparam cp_t CP_MAX    = 21'h10FFFF;
  localparam cp_t SURR_LO   = 21'h00D800;
  localparam cp_t SURR_HI   = 21'h00DFFF;
  localparam cp_t C1_LO     = 21'h000080;
  localparam cp_t C1_HI     = 21'h00009F;

  function automatic cp_t min_code_point(input min_class_t mc);
    cp_t r;
    case (mc)
      CLASS_TWO:   r = 21'h000080;
      CLASS_THREE: r = 21'h000800;
      default:     r = 21'h010000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/utf8_text_validator.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text validator
// Streaming check of a byte string against UTF-8 and text rules.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one word per byte, text_byte
//   with end_of_text set on the final byte of a string. A word is taken on
//   a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry one word per string,
//   text_valid, produced only for the byte that has end_of_text set.
// Timing:
//   One byte per cycle sustained while in_stall stays low. A byte is held
//   in the input register; its state update and verdict are done in one
//   pass of logic, and the verdict of a final byte goes into the output register.
// Stall:
//   The output register holds the verdict while out_stall is high. Bytes
//   without the end mark keep flowing; in_stall rises only while a final
//   byte waits in the input register for the output register to free up.
// Reset:
//   rst (synchronous) empties both registers and clears the decoder state,
//   so the next byte starts a new string.
// ----------------------------------------------------------------------------
module utf8_text_validator
  import utfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        text_valid
);

  // Input register.
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_eot;

  // Decoder state.
  tails_t     tails_pending, tails_pending_next;
  cp_t        code_point_acc, code_point_acc_next;
  min_class_t min_class, min_class_next;
  logic       error_seen, error_seen_next;

  logic out_free;
  logic adv;
  logic in_take;
  cp_t  cp_full;
  logic verdict;

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && (!s1_eot || out_free);
  assign in_stall = s1_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  assign cp_full = {code_point_acc[CP_W-7:0], s1_byte[5:0]};

  always_comb begin
    tails_pending_next  = tails_pending;
    code_point_acc_next = code_point_acc;
    min_class_next      = min_class;
    error_seen_next     = error_seen;
    if (!error_seen) begin
      if (tails_pending != '0) begin
        if ((s1_byte & CONT_MASK) != CONT_MARK) begin
          error_seen_next = 1'b1;
        end else begin
          code_point_acc_next = cp_full;
          tails_pending_next  = tails_pending - 2'd1;
          if (tails_pending == 2'd1) begin
            if (cp_full < min_code_point(min_class) || cp_full > CP_MAX ||
                (cp_full >= SURR_LO && cp_full <= SURR_HI) ||
                (cp_full >= C1_LO && cp_full <= C1_HI)) begin
              error_seen_next = 1'b1;
            end
          end
        end
      end else if (s1_byte <= ASCII_TOP) begin
        if (s1_byte < CTRL_LIMIT || s1_byte == DEL_BYTE) begin
          error_seen_next = 1'b1;
        end
      end else if (s1_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
        tails_pending_next  = 2'd1;
        min_class_next      = CLASS_TWO;
        code_point_acc_next = cp_t'(s1_byte[4:0]);
      end else if (s1_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
        tails_pending_next  = 2'd2;
        min_class_next      = CLASS_THREE;
        code_point_acc_next = cp_t'(s1_byte[3:0]);
      end else if (s1_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
        tails_pending_next  = 2'd3;
        min_class_next      = CLASS_FOUR;
        code_point_acc_next = cp_t'(s1_byte[2:0]);
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  assign verdict = !error_seen_next && (tails_pending_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= text_byte;
      s1_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tails_pending  <= '0;
      code_point_acc <= '0;
      min_class      <= '0;
      error_seen     <= 1'b0;
    end else if (adv) begin
      if (s1_eot) begin
        // The string ends here, so the next byte opens a fresh one.
        tails_pending  <= '0;
        code_point_acc <= '0;
        min_class      <= '0;
        error_seen     <= 1'b0;
      end else begin
        tails_pending  <= tails_pending_next;
        code_point_acc <= code_point_acc_next;
        min_class      <= min_class_next;
        error_seen     <= error_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_eot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_eot) begin
      text_valid <= verdict;
    end
  end

`ifndef NO_ASSERTIONS
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    min_class != 2'd3)
    else $error("min_class holds an unused code");

  a_four_byte_class: assert property (@(posedge clk) disable iff (rst)
    tails_pending == 2'd3 |-> min_class == CLASS_FOUR)
    else $error("three tails pending outside a four-byte sequence");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_eot && out_valid && out_stall))
    else $error("input stalled without a blocked verdict");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_eot) |=> (out_valid && tails_pending == '0 && !error_seen))
    else $error("end of string did not clear state or post a verdict");
`endif

endmodule

// ----- sim/tb_utf8_text_validator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 text validator testbench
// Feeds byte strings, mostly well-formed UTF-8 text with random content plus
// broken sequences and noise, and checks each end-of-text verdict against a
// predictor kept alongside the block. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_text_validator;
  import utfv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 500;
  localparam int DRAIN_CYCLES = 10;

  localparam cp_t MIN_CP_TWO   = 21'h000080;
  localparam cp_t MIN_CP_THREE = 21'h000800;
  localparam cp_t MIN_CP_FOUR  = 21'h010000;

  typedef struct packed {
    byte_t data;
    logic  is_last;
  } text_word_t;

  logic  clk         = 1'b0;
  logic  rst         = 1'b1;
  logic  in_valid    = 1'b0;
  logic  in_stall;
  byte_t text_byte   = '0;
  logic  end_of_text = 1'b0;
  logic  out_valid;
  logic  out_stall   = 1'b0;
  logic  text_valid;

  text_word_t pend_q[$];
  byte_t      draft_q[$];
  logic       verdict_q[$];

  // Predictor state, cleared at the end of every string.
  tails_t     tails_left = '0;
  cp_t        cp_acc     = '0;
  min_class_t seq_class  = CLASS_TWO;
  logic       err_flag   = 1'b0;

  logic exp_verdict;
  logic in_fire     = 1'b0;
  int   in_gap      = 0;
  int   stall_left  = 0;
  int   calm_left   = 0;
  int   words_taken = 0;
  int   total_words = 0;
  int   fail_cnt    = 0;
  int   cycle_cnt   = 0;

  utf8_text_validator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .text_valid  (text_valid)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void flag_error(string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0d: %s", cycle_cnt, what);
  endfunction

  // ---------------------------------------------------------------------------
  // String construction
  // ---------------------------------------------------------------------------
  function automatic void flush_text();
    text_word_t w;
    for (int i = 0; i < draft_q.size(); i++) begin
      w.data    = draft_q[i];
      w.is_last = (i == draft_q.size() - 1);
      pend_q.push_back(w);
    end
    draft_q.delete();
  endfunction

  // Raw bytes, most significant byte first.
  function automatic void add_text(int n, logic [31:0] raw);
    for (int i = n - 1; i >= 0; i--) draft_q.push_back(raw[8*i +: 8]);
    flush_text();
  endfunction

  // Encodes a code point in the given number of bytes, whether or not that
  // length is legal for it, so overlong and out-of-range forms come out too.
  function automatic void put_seq(cp_t cp, int unsigned len);
    case (len)
      1: draft_q.push_back({1'b0, cp[6:0]});
      2: begin
        draft_q.push_back({3'b110, cp[10:6]});
        draft_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        draft_q.push_back({4'b1110, cp[15:12]});
        draft_q.push_back({2'b10, cp[11:6]});
        draft_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        draft_q.push_back({5'b11110, cp[20:18]});
        draft_q.push_back({2'b10, cp[17:12]});
        draft_q.push_back({2'b10, cp[11:6]});
        draft_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void put_good_char();
    cp_t         cp;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      cp = cp_t'($urandom_range('h20, 'h7E));
    end else if (r < 55) begin
      cp = cp_t'($urandom_range('hA0, 'h7FF));
    end else if (r < 70) begin
      cp = cp_t'($urandom_range('h800, 'hFFFF));
      if (cp >= SURR_LO && cp <= SURR_HI) cp = cp + 21'h000800;
    end else if (r < 80) begin
      cp = cp_t'($urandom_range('h10000, 'h10FFFF));
    end else begin
      case ($urandom_range(0, 7))
        0:       cp = 21'h0000A0;
        1:       cp = 21'h0007FF;
        2:       cp = 21'h000800;
        3:       cp = 21'h00D7FF;
        4:       cp = 21'h00E000;
        5:       cp = 21'h00FFFF;
        6:       cp = 21'h010000;
        default: cp = CP_MAX;
      endcase
    end
    if (cp < MIN_CP_TWO) put_seq(cp, 1);
    else if (cp < MIN_CP_THREE) put_seq(cp, 2);
    else if (cp < MIN_CP_FOUR) put_seq(cp, 3);
    else put_seq(cp, 4);
  endfunction

  function automatic cp_t bad_code_point();
    case ($urandom_range(0, 9))
      0:       return 21'h000000;
      1:       return 21'h00001F;
      2:       return 21'h00007F;
      3:       return C1_LO;
      4:       return C1_HI;
      5:       return SURR_LO;
      6:       return SURR_HI;
      7:       return CP_MAX + 21'd1;
      8:       return 21'h0007FF;
      default: return cp_t'($urandom);
    endcase
  endfunction

  function automatic void add_random_text();
    int unsigned n_chars;
    int unsigned kind;
    int unsigned bad_at;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    kind    = $urandom_range(0, 99);
    bad_at  = $urandom_range(0, n_chars - 1);
    if (kind < 10) begin
      repeat (n_chars) draft_q.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < n_chars; i++) begin
        if (kind < 30 && i == bad_at) put_seq(bad_code_point(), $urandom_range(1, 4));
        put_good_char();
      end
      if (kind >= 30 && kind < 38) begin
        draft_q[$urandom_range(0, draft_q.size() - 1)] = byte_t'($urandom_range(0, 255));
      end else if (kind >= 38 && kind < 45 && draft_q.size() > 1) begin
        draft_q.delete(draft_q.size() - 1);
      end
    end
    flush_text();
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict prediction
  // ---------------------------------------------------------------------------
  function automatic void predict_word(byte_t b, logic is_last);
    cp_t cp_min;
    if (!err_flag) begin
      if (tails_left != '0) begin
        if ((b & CONT_MASK) != CONT_MARK) begin
          err_flag = 1'b1;
        end else begin
          cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
          tails_left = tails_left - 2'd1;
          if (tails_left == '0) begin
            case (seq_class)
              CLASS_TWO:   cp_min = MIN_CP_TWO;
              CLASS_THREE: cp_min = MIN_CP_THREE;
              default:     cp_min = MIN_CP_FOUR;
            endcase
            if (cp_acc < cp_min || cp_acc > CP_MAX ||
                (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
                (cp_acc >= C1_LO && cp_acc <= C1_HI)) err_flag = 1'b1;
          end
        end
      end else if (b <= ASCII_TOP) begin
        if (b < CTRL_LIMIT || b == DEL_BYTE) err_flag = 1'b1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        tails_left = 2'd1;
        seq_class  = CLASS_TWO;
        cp_acc     = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        tails_left = 2'd2;
        seq_class  = CLASS_THREE;
        cp_acc     = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        tails_left = 2'd3;
        seq_class  = CLASS_FOUR;
        cp_acc     = {18'd0, b[2:0]};
      end else begin
        err_flag = 1'b1;
      end
    end
    if (is_last) begin
      verdict_q.push_back(!err_flag && tails_left == '0);
      tails_left = '0;
      cp_acc     = '0;
      seq_class  = CLASS_TWO;
      err_flag   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pend_q.size() > 0) begin
        in_valid    <= 1'b1;
        text_byte   <= pend_q[0].data;
        end_of_text <= pend_q[0].is_last;
        pend_q.delete(0);
        in_gap      <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      predict_word(text_byte, end_of_text);
      words_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("verdict %0b with no string pending", text_valid));
      end else begin
        exp_verdict = verdict_q.pop_front();
        if (text_valid !== exp_verdict)
          flag_error($sformatf("text_valid: expected %0b, got %0b", exp_verdict, text_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    add_text(4, 32'h207EC2A0);  // printable ends and a plain two-byte character
    add_text(1, 32'h00000000);  // lowest control byte
    add_text(1, 32'h000000FF);  // byte that can never lead
    add_text(2, 32'h0000C280);  // C1 control in two bytes
    add_text(3, 32'h00E08080);  // overlong three-byte form
    add_text(3, 32'h00EDA080);  // surrogate
    add_text(4, 32'hF4908080);  // above the last code point
    add_text(4, 32'hF09F9880);  // legal four-byte character
    add_text(2, 32'h0000F580);  // lead byte past F4
    add_text(2, 32'h0000E241);  // ASCII where a continuation word belongs
    add_text(3, 32'h00C17F41);  // bad lead, the rest of the string ignored
    add_text(2, 32'h0000E282);  // string cut short inside a sequence
    total_words = pend_q.size() + RANDOM_WORDS;
    while (pend_q.size() < total_words) add_random_text();
    total_words = pend_q.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    while (words_taken < total_words) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/utfv_pkg.sv
rtl/utf8_text_validator.sv
sim/tb_utf8_text_validator.sv
